>>> src/heading_to_wheel_speed_steering_defines.svh
// Assertion macros shared by the steering block.
`ifndef HEADING_TO_WHEEL_SPEED_STEERING_DEFINES_SVH
`define HEADING_TO_WHEEL_SPEED_STEERING_DEFINES_SVH

// An implication that must hold at every clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");

// A condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");

`endif

>>> src/hws_pkg.sv
package hws_pkg;

   typedef enum logic [1:0] {
      MODE_NONE = 2'd0,
      MODE_SOFT = 2'd1,
      MODE_HARD = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      REG_HARD = 2'd0,
      REG_SOFT = 2'd1,
      REG_NONE = 2'd2,
      REG_MAX  = 2'd3
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ITER,
      ST_ANGLE,
      ST_MODE,
      ST_DIV,
      ST_SPEED,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic load;     // take a new word into the datapath
      logic iter;     // one CORDIC and one square-root step
      logic angle;    // round and limit the angle, clamp the base speed
      logic mode;     // settle the turn mode and set up the divider
      logic div_step; // one restoring divider step
      logic speed;    // form the wheel speeds
   } cmd_type;

   typedef struct packed {
      logic iter_last;
      logic div_last;
   } status_type;

   localparam int IterCount = 16;
   localparam int DivCount = 30;
   localparam logic signed [18:0] PiQ13 = 19'sd25736;
   localparam logic signed [18:0] HalfPiQ13 = 19'sd12868;
   localparam logic signed [21:0] PiQ16 = 22'sd205887;

   function automatic logic [16:0] atan_lookup(input logic [3:0] i);
      case (i)
         4'd0: atan_lookup = 17'd51472;
         4'd1: atan_lookup = 17'd30386;
         4'd2: atan_lookup = 17'd16055;
         4'd3: atan_lookup = 17'd8150;
         4'd4: atan_lookup = 17'd4091;
         4'd5: atan_lookup = 17'd2047;
         4'd6: atan_lookup = 17'd1024;
         4'd7: atan_lookup = 17'd512;
         4'd8: atan_lookup = 17'd256;
         4'd9: atan_lookup = 17'd128;
         4'd10: atan_lookup = 17'd64;
         4'd11: atan_lookup = 17'd32;
         4'd12: atan_lookup = 17'd16;
         4'd13: atan_lookup = 17'd8;
         4'd14: atan_lookup = 17'd4;
         default: atan_lookup = 17'd2;
      endcase
   endfunction

endpackage

>>> src/heading_to_wheel_speed_steering.sv
// Steering for a differential drive: each request word carries a heading
// vector, and one response word follows with both wheel speeds and the turn
// mode after the step. From acceptance to a valid response a word passes
// through 16 combined CORDIC and square-root steps, a state for the angle
// and one for the mode, a 30-step restoring divider for the soft-turn speed
// difference and a state for the speeds; the next word is taken
// once the response has gone.
module heading_to_wheel_speed_steering (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_heading_x,
   input  logic signed [15:0] req_heading_y,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_left_speed,
   output logic signed [15:0] rsp_right_speed,
   output logic [1:0]         rsp_turn_mode,
   input  logic               csr_write,
   input  logic [1:0]         csr_index,
   input  logic [14:0]        csr_data
);
   import hws_pkg::*;
   `include "heading_to_wheel_speed_steering_defines.svh"

   logic [14:0] hard_ff, soft_ff, none_ff;
   logic [13:0] max_ff;
   cmd_type     cmd;
   status_type  status;
   mode_type    mode;

   always_ff @(posedge clock) begin
      if (reset) begin
         hard_ff <= 15'd7150;
         soft_ff <= 15'd5720;
         none_ff <= 15'd1430;
         max_ff <= 14'd2560;
      end else if (csr_write) begin
         case (reg_index_type'(csr_index))
            REG_HARD: hard_ff <= csr_data;
            REG_SOFT: soft_ff <= csr_data;
            REG_NONE: none_ff <= csr_data;
            REG_MAX: max_ff <= csr_data[13:0];
            default: begin
            end
         endcase
      end
   end

   hws_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .rsp_stall(rsp_stall),
      .status(status), .cmd(cmd), .req_stall(req_stall), .rsp_valid(rsp_valid)
   );

   hws_dp u_dp (
      .clock(clock), .reset(reset), .cmd(cmd),
      .req_heading_x(req_heading_x), .req_heading_y(req_heading_y),
      .hard_thr(hard_ff), .soft_thr(soft_ff), .none_thr(none_ff), .speed_limit(max_ff),
      .status(status), .rsp_left_speed(rsp_left_speed),
      .rsp_right_speed(rsp_right_speed), .rsp_turn_mode(mode)
   );

   assign rsp_turn_mode = mode;

   `ASSERT_ALWAYS(a_mode_code, clock, reset, rsp_turn_mode != 2'd3)
   `ASSERT_IMPLIES(a_busy_while_valid, clock, reset, rsp_valid, req_stall)
   `ASSERT_IMPLIES(a_hard_spin, clock, reset,
      rsp_valid && rsp_turn_mode == MODE_HARD,
      rsp_left_speed == -rsp_right_speed)

endmodule

>>> src/hws_ctrl.sv
module hws_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                rsp_stall,
   input  hws_pkg::status_type status,
   output hws_pkg::cmd_type    cmd,
   output logic                req_stall,
   output logic                rsp_valid
);
   import hws_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_ITER;
            end
         end
         ST_ITER: begin
            cmd.iter = 1'b1;
            if (status.iter_last) begin
               state_in = ST_ANGLE;
            end
         end
         ST_ANGLE: begin
            cmd.angle = 1'b1;
            state_in = ST_MODE;
         end
         ST_MODE: begin
            cmd.mode = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_SPEED;
            end
         end
         ST_SPEED: begin
            cmd.speed = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> src/hws_dp.sv
module hws_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  hws_pkg::cmd_type     cmd,
   input  logic signed [15:0]   req_heading_x,
   input  logic signed [15:0]   req_heading_y,
   input  logic [14:0]          hard_thr,
   input  logic [14:0]          soft_thr,
   input  logic [14:0]          none_thr,
   input  logic [13:0]          speed_limit,
   output hws_pkg::status_type  status,
   output logic signed [15:0]   rsp_left_speed,
   output logic signed [15:0]   rsp_right_speed,
   output hws_pkg::mode_type    rsp_turn_mode
);
   import hws_pkg::*;

   // CORDIC registers: x grows by at most 1.65, so 27 bits carry it safely.
   logic signed [26:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [21:0] cz_ff, cz_in;
   logic [3:0]         cnt_ff;
   logic               special_ff;
   logic signed [18:0] special_ang_ff;
   // Square root of a 32-bit sum, two bits per step.
   logic [31:0]        rem_ff, rem_in;
   logic [15:0]        root_ff, root_in;
   logic [31:0]        sq_ff;
   logic signed [18:0] ang_ff;
   logic [14:0]        mag_ff;
   logic [13:0]        base_ff;
   mode_type           mode_ff, mode_in;
   // Divider: quotient of (2*base*mag + hard) by 2*hard.
   logic [29:0]        num_ff;
   logic [15:0]        part_ff;
   logic [4:0]         dcnt_ff;
   logic [29:0]        quo_ff;
   logic signed [15:0] left_ff, right_ff;

   logic signed [26:0] dx, dy;
   logic signed [21:0] z_round;
   logic signed [18:0] ang_calc;
   logic [33:0]        trial;
   logic [16:0]        part_sh;
   logic [31:0]        sqx, sqy;
   logic signed [16:0] sin_v, sout_v;

   assign status.iter_last = (cnt_ff == 4'(IterCount - 1));
   assign status.div_last = (dcnt_ff == 5'(DivCount - 1));

   assign dx = cy_ff >>> cnt_ff;
   assign dy = cx_ff >>> cnt_ff;
   assign sqx = 32'($signed(req_heading_x) * $signed(req_heading_x));
   assign sqy = 32'($signed(req_heading_y) * $signed(req_heading_y));

   always_comb begin
      cx_in = cx_ff;
      cy_in = cy_ff;
      cz_in = cz_ff;
      if (!cy_ff[26]) begin
         cx_in = cx_ff + dx;
         cy_in = cy_ff - dy;
         cz_in = cz_ff + $signed({5'd0, atan_lookup(cnt_ff)});
      end else begin
         cx_in = cx_ff - dx;
         cy_in = cy_ff + dy;
         cz_in = cz_ff - $signed({5'd0, atan_lookup(cnt_ff)});
      end
   end

   // One step of the bitwise square root: the trial is 4*rem + next pair - (4*root + 1).
   assign trial = {rem_ff, sq_ff[31:30]} - {16'd0, root_ff, 2'b01};
   always_comb begin
      if (!trial[33]) begin
         rem_in = trial[31:0];
         root_in = {root_ff[14:0], 1'b1};
      end else begin
         rem_in = {rem_ff[29:0], sq_ff[31:30]};
         root_in = {root_ff[14:0], 1'b0};
      end
   end

   assign z_round = (cz_ff + 22'sd4) >>> 3;
   always_comb begin
      if (special_ff) begin
         ang_calc = special_ang_ff;
      end else if (z_round > 22'(PiQ13)) begin
         ang_calc = PiQ13;
      end else if (z_round < -22'(PiQ13) + 22'sd1) begin
         ang_calc = -PiQ13 + 19'sd1;
      end else begin
         ang_calc = z_round[18:0];
      end
   end

   // Hysteresis cascade, each check seeing the mode the previous one left.
   always_comb begin
      mode_in = mode_ff;
      if (mode_in == MODE_HARD && mag_ff <= soft_thr) begin
         mode_in = MODE_SOFT;
      end
      if (mode_in == MODE_SOFT) begin
         if (mag_ff > hard_thr) begin
            mode_in = MODE_HARD;
         end else if (mag_ff <= none_thr) begin
            mode_in = MODE_NONE;
         end
      end else if (mode_in != MODE_HARD) begin
         if (mag_ff > hard_thr) begin
            mode_in = MODE_HARD;
         end else if (mag_ff > none_thr) begin
            mode_in = MODE_SOFT;
         end else begin
            mode_in = MODE_NONE;
         end
      end
   end

   assign part_sh = {part_ff, num_ff[29]};

   always_comb begin
      case (mode_ff)
         MODE_SOFT: begin
            sin_v = $signed({3'd0, base_ff}) - $signed({1'b0, quo_ff[15:0]});
            sout_v = $signed({3'd0, base_ff}) + $signed({1'b0, quo_ff[15:0]});
         end
         MODE_HARD: begin
            sin_v = -$signed({3'd0, speed_limit});
            sout_v = $signed({3'd0, speed_limit});
         end
         default: begin
            sin_v = $signed({3'd0, base_ff});
            sout_v = $signed({3'd0, base_ff});
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_NONE;
      end else if (cmd.mode) begin
         mode_ff <= mode_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cnt_ff <= '0;
         special_ff <= (req_heading_x == 16'sd0) || (req_heading_y == 16'sd0);
         if (req_heading_y == 16'sd0) begin
            special_ang_ff <= req_heading_x[15] ? PiQ13 : 19'sd0;
         end else begin
            special_ang_ff <= req_heading_y[15] ? -HalfPiQ13 : HalfPiQ13;
         end
         if (req_heading_x[15]) begin
            cz_ff <= req_heading_y[15] ? -PiQ16 : PiQ16;
            cx_ff <= -{{3{req_heading_x[15]}}, req_heading_x, 8'd0};
            cy_ff <= -{{3{req_heading_y[15]}}, req_heading_y, 8'd0};
         end else begin
            cz_ff <= '0;
            cx_ff <= {{3{req_heading_x[15]}}, req_heading_x, 8'd0};
            cy_ff <= {{3{req_heading_y[15]}}, req_heading_y, 8'd0};
         end
         sq_ff <= sqx + sqy;
         rem_ff <= '0;
         root_ff <= '0;
      end
      if (cmd.iter) begin
         cx_ff <= cx_in;
         cy_ff <= cy_in;
         cz_ff <= cz_in;
         cnt_ff <= cnt_ff + 4'd1;
         rem_ff <= rem_in;
         root_ff <= root_in;
         sq_ff <= {sq_ff[29:0], 2'b00};
      end
      if (cmd.angle) begin
         ang_ff <= ang_calc;
         mag_ff <= ang_calc[18] ? 15'(-ang_calc) : 15'(ang_calc);
         base_ff <= (root_ff < {2'd0, speed_limit}) ? root_ff[13:0] : speed_limit;
      end
      if (cmd.mode) begin
         num_ff <= 30'({base_ff, 1'b0} * mag_ff) + 30'(hard_thr);
         part_ff <= '0;
         dcnt_ff <= '0;
         quo_ff <= '0;
      end
      if (cmd.div_step) begin
         dcnt_ff <= dcnt_ff + 5'd1;
         num_ff <= {num_ff[28:0], 1'b0};
         if (part_sh >= {1'b0, hard_thr, 1'b0}) begin
            part_ff <= 16'(part_sh - {1'b0, hard_thr, 1'b0});
            quo_ff <= {quo_ff[28:0], 1'b1};
         end else begin
            part_ff <= part_sh[15:0];
            quo_ff <= {quo_ff[28:0], 1'b0};
         end
      end
      if (cmd.speed) begin
         if (hard_thr == 15'd0 && mode_ff == MODE_SOFT) begin
            left_ff <= $signed({2'd0, base_ff});
            right_ff <= $signed({2'd0, base_ff});
         end else if (!ang_ff[18] && ang_ff != 19'sd0) begin
            left_ff <= sin_v[15:0];
            right_ff <= sout_v[15:0];
         end else begin
            left_ff <= sout_v[15:0];
            right_ff <= sin_v[15:0];
         end
      end
   end

   assign rsp_left_speed = left_ff;
   assign rsp_right_speed = right_ff;
   assign rsp_turn_mode = mode_ff;

endmodule
